### rtl/scancode_set1_key_decoder_defines.svh
// Assertion macros for the set-1 scancode key decoder checker.
// No dependencies; included by the checker file.
`ifndef SCANCODE_SET1_KEY_DECODER_DEFINES_SVH
`define SCANCODE_SET1_KEY_DECODER_DEFINES_SVH

// Same-cycle implication, ignored while reset is asserted.
`define SCS1_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, ignored while reset is asserted.
`define SCS1_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

// Next-cycle implication that is also checked across reset.
`define SCS1_ASSERT_NEXT_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/scs1_pkg.sv
// Shared types, scancode constants and the character lookup for the set-1 decoder.
// No dependencies.
package scs1_pkg;

  typedef logic [2:0] event_kind_t;
  typedef logic [6:0] char_code_t;
  typedef logic [7:0] scan_byte_t;

  localparam event_kind_t EV_CHAR  = 3'd0;
  localparam event_kind_t EV_UP    = 3'd1;
  localparam event_kind_t EV_DOWN  = 3'd2;
  localparam event_kind_t EV_LEFT  = 3'd3;
  localparam event_kind_t EV_RIGHT = 3'd4;
  localparam event_kind_t EV_SAVE  = 3'd5;
  localparam event_kind_t EV_QUIT  = 3'd6;

  localparam scan_byte_t SC_PREFIX      = 8'hE0;
  localparam scan_byte_t SC_UP          = 8'h48;
  localparam scan_byte_t SC_DOWN        = 8'h50;
  localparam scan_byte_t SC_LEFT        = 8'h4B;
  localparam scan_byte_t SC_RIGHT       = 8'h4D;
  localparam scan_byte_t SC_LSHIFT_MAKE = 8'h2A;
  localparam scan_byte_t SC_RSHIFT_MAKE = 8'h36;
  localparam scan_byte_t SC_LSHIFT_BRK  = 8'hAA;
  localparam scan_byte_t SC_RSHIFT_BRK  = 8'hB6;
  localparam scan_byte_t SC_CTRL_MAKE   = 8'h1D;
  localparam scan_byte_t SC_CTRL_BRK    = 8'h9D;
  localparam scan_byte_t SC_KEY_O       = 8'h18;
  localparam scan_byte_t SC_KEY_X       = 8'h2D;
  localparam scan_byte_t SC_ENTER       = 8'h1C;
  localparam scan_byte_t SC_BACKSPACE   = 8'h0E;
  localparam scan_byte_t SC_SPACE       = 8'h39;
  localparam scan_byte_t SC_TABLE_END   = 8'h36;

  localparam char_code_t CH_LF    = 7'd10;
  localparam char_code_t CH_BS    = 7'd8;
  localparam char_code_t CH_SPACE = 7'd32;
  localparam char_code_t CH_NONE  = 7'd0;

  typedef struct packed {
    logic        emit;
    event_kind_t kind;
    char_code_t  code;
  } dec_res_t;

  // Shift-aware key table; zero means no character for that code.
  function automatic char_code_t key_char(input logic [5:0] idx, input logic sh);
    char_code_t ch;
    ch = CH_NONE;
    unique case (idx)
      6'h02: ch = sh ? 7'h21 : 7'h31;
      6'h03: ch = sh ? 7'h40 : 7'h32;
      6'h04: ch = sh ? 7'h23 : 7'h33;
      6'h05: ch = sh ? 7'h24 : 7'h34;
      6'h06: ch = sh ? 7'h25 : 7'h35;
      6'h07: ch = sh ? 7'h5E : 7'h36;
      6'h08: ch = sh ? 7'h26 : 7'h37;
      6'h09: ch = sh ? 7'h2A : 7'h38;
      6'h0A: ch = sh ? 7'h28 : 7'h39;
      6'h0B: ch = sh ? 7'h29 : 7'h30;
      6'h0C: ch = sh ? 7'h5F : 7'h2D;
      6'h0D: ch = sh ? 7'h2B : 7'h3D;
      6'h10: ch = sh ? 7'h51 : 7'h71;
      6'h11: ch = sh ? 7'h57 : 7'h77;
      6'h12: ch = sh ? 7'h45 : 7'h65;
      6'h13: ch = sh ? 7'h52 : 7'h72;
      6'h14: ch = sh ? 7'h54 : 7'h74;
      6'h15: ch = sh ? 7'h59 : 7'h79;
      6'h16: ch = sh ? 7'h55 : 7'h75;
      6'h17: ch = sh ? 7'h49 : 7'h69;
      6'h18: ch = sh ? 7'h4F : 7'h6F;
      6'h19: ch = sh ? 7'h50 : 7'h70;
      6'h1A: ch = sh ? 7'h7B : 7'h5B;
      6'h1B: ch = sh ? 7'h7D : 7'h5D;
      6'h1E: ch = sh ? 7'h41 : 7'h61;
      6'h1F: ch = sh ? 7'h53 : 7'h73;
      6'h20: ch = sh ? 7'h44 : 7'h64;
      6'h21: ch = sh ? 7'h46 : 7'h66;
      6'h22: ch = sh ? 7'h47 : 7'h67;
      6'h23: ch = sh ? 7'h48 : 7'h68;
      6'h24: ch = sh ? 7'h4A : 7'h6A;
      6'h25: ch = sh ? 7'h4B : 7'h6B;
      6'h26: ch = sh ? 7'h4C : 7'h6C;
      6'h27: ch = sh ? 7'h3A : 7'h3B;
      6'h28: ch = sh ? 7'h22 : 7'h27;
      6'h29: ch = sh ? 7'h7E : 7'h60;
      6'h2B: ch = sh ? 7'h7C : 7'h5C;
      6'h2C: ch = sh ? 7'h5A : 7'h7A;
      6'h2D: ch = sh ? 7'h58 : 7'h78;
      6'h2E: ch = sh ? 7'h43 : 7'h63;
      6'h2F: ch = sh ? 7'h56 : 7'h76;
      6'h30: ch = sh ? 7'h42 : 7'h62;
      6'h31: ch = sh ? 7'h4E : 7'h6E;
      6'h32: ch = sh ? 7'h4D : 7'h6D;
      6'h33: ch = sh ? 7'h3C : 7'h2C;
      6'h34: ch = sh ? 7'h3E : 7'h2E;
      6'h35: ch = sh ? 7'h3F : 7'h2F;
      default: ch = CH_NONE;
    endcase
    return ch;
  endfunction

endpackage

### rtl/scancode_set1_key_decoder.sv
// Top level of the set-1 scancode key decoder.
// Depends on scs1_pkg, scs1_in_reg, scs1_decode and scs1_out_reg.
//
// Usage:
//   Input channel in_valid/in_ready/in_scan_byte carries one raw set-1 byte
//   per transaction. Output channel out_valid/out_ready carries one event per
//   transaction: out_event_kind and out_char_code (zero unless a character).
//   A byte yields zero or one event; prefix, shift, ctrl, break and unmapped
//   bytes give no transaction and at most update the flags.
//   Path: a byte accepted into the input register is decoded and its event
//   is loaded into the result register. Throughput: one byte per cycle while
//   the output slot is free, set by the single decode stage between the registers.
//   Stall: while out_ready is low and a result waits, a decoded byte that
//   needs no output slot still drains; the input register fills and then
//   in_ready drops until the result is taken. Nothing is lost.
//   Reset (rst_n low, synchronous): clears both valids and the shift, ctrl
//   and prefix flags.
module scancode_set1_key_decoder (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  scs1_pkg::scan_byte_t  in_scan_byte,
  output logic                  out_valid,
  input  logic                  out_ready,
  output scs1_pkg::event_kind_t out_event_kind,
  output scs1_pkg::char_code_t  out_char_code
);
  import scs1_pkg::*;

  logic       byte_valid;
  scan_byte_t byte_q;
  logic       slot_free;
  logic       take;
  dec_res_t   res;

  assign take = byte_valid && (slot_free || !res.emit);

  scs1_in_reg u_in (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_scan_byte(in_scan_byte),
    .take        (take),
    .byte_valid  (byte_valid),
    .byte_q      (byte_q)
  );

  scs1_decode u_dec (
    .clk   (clk),
    .rst_n (rst_n),
    .take  (take),
    .byte_q(byte_q),
    .res   (res)
  );

  scs1_out_reg u_out (
    .clk           (clk),
    .rst_n         (rst_n),
    .take          (take),
    .res           (res),
    .slot_free     (slot_free),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_event_kind(out_event_kind),
    .out_char_code (out_char_code)
  );

endmodule

### rtl/scs1_in_reg.sv
// Input register for the set-1 decoder: holds one scancode byte until decoded.
// Depends on scs1_pkg.
module scs1_in_reg (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  scs1_pkg::scan_byte_t in_scan_byte,
  input  logic                 take,
  output logic                 byte_valid,
  output scs1_pkg::scan_byte_t byte_q
);
  import scs1_pkg::*;

  logic       valid_r;
  logic       valid_nxt;
  scan_byte_t byte_r;

  assign in_ready   = !valid_r || take;
  assign byte_valid = valid_r;
  assign byte_q     = byte_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_r <= in_scan_byte;
    end
  end

endmodule

### rtl/scs1_decode.sv
// Scancode decode: shift, ctrl and prefix flags plus the per-byte event logic.
// Depends on scs1_pkg.
module scs1_decode (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 take,
  input  scs1_pkg::scan_byte_t byte_q,
  output scs1_pkg::dec_res_t   res
);
  import scs1_pkg::*;

  logic shift_r, shift_nxt;
  logic ctrl_r, ctrl_nxt;
  logic prefix_r, prefix_nxt;
  char_code_t tbl_ch;

  assign tbl_ch = key_char(byte_q[5:0], shift_r);

  always_comb begin
    shift_nxt  = shift_r;
    ctrl_nxt   = ctrl_r;
    prefix_nxt = prefix_r;
    res        = '{emit: 1'b0, kind: EV_CHAR, code: CH_NONE};
    priority if (prefix_r) begin
      prefix_nxt = 1'b0;
      priority if (byte_q == SC_UP) begin
        res = '{emit: 1'b1, kind: EV_UP, code: CH_NONE};
      end else if (byte_q == SC_DOWN) begin
        res = '{emit: 1'b1, kind: EV_DOWN, code: CH_NONE};
      end else if (byte_q == SC_LEFT) begin
        res = '{emit: 1'b1, kind: EV_LEFT, code: CH_NONE};
      end else if (byte_q == SC_RIGHT) begin
        res = '{emit: 1'b1, kind: EV_RIGHT, code: CH_NONE};
      end else begin
        res.emit = 1'b0;
      end
    end else if (byte_q == SC_PREFIX) begin
      prefix_nxt = 1'b1;
    end else if (byte_q == SC_LSHIFT_MAKE || byte_q == SC_RSHIFT_MAKE) begin
      shift_nxt = 1'b1;
    end else if (byte_q == SC_LSHIFT_BRK || byte_q == SC_RSHIFT_BRK) begin
      shift_nxt = 1'b0;
    end else if (byte_q == SC_CTRL_MAKE) begin
      ctrl_nxt = 1'b1;
    end else if (byte_q == SC_CTRL_BRK) begin
      ctrl_nxt = 1'b0;
    end else if (byte_q[7]) begin
      res.emit = 1'b0;
    end else if (ctrl_r) begin
      priority if (byte_q == SC_KEY_O) begin
        res = '{emit: 1'b1, kind: EV_SAVE, code: CH_NONE};
      end else if (byte_q == SC_KEY_X) begin
        res = '{emit: 1'b1, kind: EV_QUIT, code: CH_NONE};
      end else begin
        res.emit = 1'b0;
      end
    end else if (byte_q == SC_ENTER) begin
      res = '{emit: 1'b1, kind: EV_CHAR, code: CH_LF};
    end else if (byte_q == SC_BACKSPACE) begin
      res = '{emit: 1'b1, kind: EV_CHAR, code: CH_BS};
    end else if (byte_q == SC_SPACE) begin
      res = '{emit: 1'b1, kind: EV_CHAR, code: CH_SPACE};
    end else if (byte_q < SC_TABLE_END) begin
      res = '{emit: (tbl_ch != CH_NONE), kind: EV_CHAR, code: tbl_ch};
    end else begin
      res.emit = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r  <= 1'b0;
      ctrl_r   <= 1'b0;
      prefix_r <= 1'b0;
    end else if (take) begin
      shift_r  <= shift_nxt;
      ctrl_r   <= ctrl_nxt;
      prefix_r <= prefix_nxt;
    end
  end

endmodule

### rtl/scs1_out_reg.sv
// Result register for the set-1 decoder: holds one event until the receiver takes it.
// Depends on scs1_pkg.
module scs1_out_reg (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    take,
  input  scs1_pkg::dec_res_t      res,
  output logic                    slot_free,
  output logic                    out_valid,
  input  logic                    out_ready,
  output scs1_pkg::event_kind_t   out_event_kind,
  output scs1_pkg::char_code_t    out_char_code
);
  import scs1_pkg::*;

  logic        valid_r, valid_nxt;
  logic        load;
  event_kind_t kind_r;
  char_code_t  code_r;

  assign slot_free      = !valid_r || out_ready;
  assign load           = take && res.emit;
  assign out_valid      = valid_r;
  assign out_event_kind = kind_r;
  assign out_char_code  = code_r;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind_r <= res.kind;
      code_r <= res.code;
    end
  end

endmodule

### rtl/scs1_checker.sv
// Port-level checker for the set-1 scancode key decoder, bound to the top level.
// Depends on scs1_pkg and scancode_set1_key_decoder_defines.svh.
`include "scancode_set1_key_decoder_defines.svh"

module scs1_checker (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_ready,
  input scs1_pkg::scan_byte_t  in_scan_byte,
  input logic                  out_valid,
  input logic                  out_ready,
  input scs1_pkg::event_kind_t out_event_kind,
  input scs1_pkg::char_code_t  out_char_code
);
  import scs1_pkg::*;

  `SCS1_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_event_kind) && $stable(out_char_code), "stalled result changed")
  `SCS1_ASSERT_NOW(a_noncharzero, out_valid && out_event_kind != EV_CHAR, out_char_code == CH_NONE, "char_code set on non-character event")
  `SCS1_ASSERT_NOW(a_char_nonzero, out_valid && out_event_kind == EV_CHAR, out_char_code != CH_NONE, "character event with null code")
  `SCS1_ASSERT_NOW(a_ready_follows, out_ready, in_ready, "input stalled while receiver ready")
  `SCS1_ASSERT_NEXT_RST(a_reset_idle, !rst_n, !out_valid, "result valid straight after reset")

endmodule

bind scancode_set1_key_decoder scs1_checker u_chk (.*);
